>>> hdl/drs_pkg.sv
// Shared types and constants for the disk request scheduler.
package drs_pkg;

    localparam int TRACK_FIELD_BITS = 17;
    localparam int COUNT_FIELD_BITS = 18;
    localparam int STAMP_BITS       = 32;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_ADD        = 3'd1;
    localparam logic [2:0] OP_SERVE_FCFS = 3'd2;
    localparam logic [2:0] OP_SERVE_SSTF = 3'd3;
    localparam logic [2:0] OP_SERVE_LOOK = 3'd4;
    localparam logic [2:0] OP_SERVE_CLOOK = 3'd5;

    localparam logic [2:0] STATUS_SERVED    = 3'd0;
    localparam logic [2:0] STATUS_ACCEPTED  = 3'd1;
    localparam logic [2:0] STATUS_EMPTY     = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_OUT_RANGE = 3'd4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRACK_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_HEAD  = 1'b1;

    localparam logic [COUNT_FIELD_BITS-1:0] TRACK_COUNT_RESET = 18'd131072;

    typedef struct packed {
        logic [2:0]                  operation;
        logic [TRACK_FIELD_BITS-1:0] track;
    } drs_request_t;

    typedef struct packed {
        logic [TRACK_FIELD_BITS-1:0] served_track;
        logic [2:0]                  status;
    } drs_result_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_FREE,
        ST_INSERT,
        ST_SCAN_TRACK,
        ST_PICK,
        ST_SCAN_AGE,
        ST_REMOVE
    } drs_state_t;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic init;
        logic take;
        logic match;
    } drs_scan_ctl_t;

    typedef struct packed {
        logic below_found;
        logic above_found;
    } drs_scan_flags_t;

endpackage

>>> hdl/drs_ram.sv
// Simple dual-port pending-entry memory, registered read.
module drs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 50,
    parameter int ADDR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/drs_scan.sv
// Scan unit: folds streamed entries into nearest, bounding, oldest and free candidates.
module drs_scan
    import drs_pkg::*;
#(
    parameter int TRACK_BITS = 17,
    parameter int ADDR_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drs_scan_ctl_t         ctl,
    input  logic [TRACK_BITS-1:0] head,
    input  logic [TRACK_BITS-1:0] target,
    input  logic [STAMP_BITS-1:0] counter,
    input  logic                  entry_valid,
    input  logic [TRACK_BITS-1:0] entry_track,
    input  logic [STAMP_BITS-1:0] entry_stamp,
    input  logic [ADDR_BITS-1:0]  entry_idx,
    output drs_scan_flags_t       flags,
    output logic [TRACK_BITS-1:0] max_below,
    output logic [TRACK_BITS-1:0] min_above,
    output logic [TRACK_BITS-1:0] max_all,
    output logic [TRACK_BITS-1:0] nearest,
    output logic [ADDR_BITS-1:0]  free_idx,
    output logic [ADDR_BITS-1:0]  best_idx,
    output logic [TRACK_BITS-1:0] best_track
);

    logic                  below_found_reg, above_found_reg, all_found_reg;
    logic                  near_found_reg, age_found_reg, free_found_reg;
    logic [TRACK_BITS-1:0] max_below_reg, min_above_reg, max_all_reg, nearest_reg;
    logic [TRACK_BITS-1:0] near_dist_reg, best_track_reg;
    logic [STAMP_BITS-1:0] best_age_reg;
    logic [ADDR_BITS-1:0]  free_idx_reg, best_idx_reg;

    logic [TRACK_BITS-1:0] seek_dist;
    logic [STAMP_BITS-1:0] age;
    logic                  upd_below, upd_above, upd_all, upd_near, upd_age, upd_free;

    always_comb
    begin
        seek_dist = (entry_track > head) ? entry_track - head : head - entry_track;
        age  = counter - entry_stamp;
        upd_below = ctl.take && entry_valid && (entry_track <= head)
                    && (!below_found_reg || entry_track > max_below_reg);
        upd_above = ctl.take && entry_valid && (entry_track >= head)
                    && (!above_found_reg || entry_track < min_above_reg);
        upd_all   = ctl.take && entry_valid
                    && (!all_found_reg || entry_track > max_all_reg);
        // equal distance goes to the lower track
        upd_near  = ctl.take && entry_valid
                    && (!near_found_reg || seek_dist < near_dist_reg
                        || (seek_dist == near_dist_reg && entry_track < nearest_reg));
        // strict compare keeps the lower index among equal ages
        upd_age   = ctl.take && entry_valid && (!ctl.match || entry_track == target)
                    && (!age_found_reg || age > best_age_reg);
        upd_free  = ctl.take && !entry_valid && !free_found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_found_reg <= 1'b0;
            above_found_reg <= 1'b0;
            all_found_reg   <= 1'b0;
            near_found_reg  <= 1'b0;
            age_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (ctl.init)
        begin
            below_found_reg <= 1'b0;
            above_found_reg <= 1'b0;
            all_found_reg   <= 1'b0;
            near_found_reg  <= 1'b0;
            age_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            below_found_reg <= below_found_reg | upd_below;
            above_found_reg <= above_found_reg | upd_above;
            all_found_reg   <= all_found_reg | upd_all;
            near_found_reg  <= near_found_reg | upd_near;
            age_found_reg   <= age_found_reg | upd_age;
            free_found_reg  <= free_found_reg | upd_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_below)
        begin
            max_below_reg <= entry_track;
        end
        if (upd_above)
        begin
            min_above_reg <= entry_track;
        end
        if (upd_all)
        begin
            max_all_reg <= entry_track;
        end
        if (upd_near)
        begin
            nearest_reg   <= entry_track;
            near_dist_reg <= seek_dist;
        end
        if (upd_age)
        begin
            best_idx_reg   <= entry_idx;
            best_age_reg   <= age;
            best_track_reg <= entry_track;
        end
        if (upd_free)
        begin
            free_idx_reg <= entry_idx;
        end
    end

    assign flags.below_found = below_found_reg;
    assign flags.above_found = above_found_reg;
    assign max_below  = max_below_reg;
    assign min_above  = min_above_reg;
    assign max_all    = max_all_reg;
    assign nearest    = nearest_reg;
    assign free_idx   = free_idx_reg;
    assign best_idx   = best_idx_reg;
    assign best_track = best_track_reg;

endmodule

>>> hdl/disk_request_scheduler.sv
// Disk request scheduler top level: sequencer, registers and pending-entry memory.
//
// Pending requests live in one memory of PENDING_DEPTH words, read one entry per
// cycle through a registered read port. A request is taken when start is high and
// busy is low; its single result appears on result for exactly one cycle with done
// high, and must be captured then. Clear is a write pass, an add a free-slot scan
// then the write, an FCFS serve an age scan then the removal, and SSTF, LOOK and
// C-LOOK serves a track scan, then an age scan among equal tracks, then the
// removal. Rejected adds, empty serves and unused operation codes are answered
// straight from idle, without a memory pass. After reset the memory is swept
// invalid, with busy high; configuration writes are taken at any time (cfg_ready
// is always high) but must only be made while the block is idle.
module disk_request_scheduler
    import drs_pkg::*;
#(
    parameter int PENDING_DEPTH = 256,
    parameter int TRACK_BITS    = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  drs_request_t                request,
    output logic                        done,
    output drs_result_t                 result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [COUNT_FIELD_BITS-1:0] cfg_data
);

    localparam int AW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int MW  = 1 + TRACK_BITS + STAMP_BITS;
    localparam logic [AW-1:0]  LAST_ADDR  = AW'(PENDING_DEPTH - 1);
    localparam logic [PCW-1:0] FULL_COUNT = PCW'(PENDING_DEPTH);

    drs_state_t            state_reg, state_next;
    logic [AW-1:0]         scan_addr_reg, scan_addr_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  rd_valid_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [TRACK_BITS-1:0] trk_reg, trk_next;
    logic [2:0]            op_reg, op_next;
    logic [TRACK_BITS-1:0] target_reg, target_next;
    logic                  match_reg, match_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic                  sweep_left_reg, sweep_left_next;
    logic [PCW-1:0]        pending_reg, pending_next;
    logic [STAMP_BITS-1:0] arrival_reg, arrival_next;
    logic                  done_reg, done_next;
    drs_result_t           result_reg, result_next;
    logic [COUNT_FIELD_BITS-1:0] track_count_reg;
    logic [TRACK_FIELD_BITS-1:0] start_head_reg;

    logic                  wr_en, rd_en, scan_last;
    logic [AW-1:0]         wr_addr;
    logic [MW-1:0]         wr_data, rd_data;
    logic [31:0]           req_trk_wide, start_head_wide, served_wide;
    logic [TRACK_BITS-1:0] req_trk, start_head_tb;
    logic                  out_of_range;

    drs_scan_ctl_t         scan_ctl;
    drs_scan_flags_t       scan_flags;
    logic [TRACK_BITS-1:0] max_below, min_above, max_all, nearest, best_track;
    logic [AW-1:0]         free_idx, best_idx;

    drs_ram #(
        .DEPTH     (PENDING_DEPTH),
        .WIDTH     (MW),
        .ADDR_BITS (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    drs_scan #(
        .TRACK_BITS (TRACK_BITS),
        .ADDR_BITS  (AW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .head        (head_reg),
        .target      (target_reg),
        .counter     (arrival_reg),
        .entry_valid (rd_data[MW-1]),
        .entry_track (rd_data[MW-2:STAMP_BITS]),
        .entry_stamp (rd_data[STAMP_BITS-1:0]),
        .entry_idx   (rd_idx_reg),
        .flags       (scan_flags),
        .max_below   (max_below),
        .min_above   (min_above),
        .max_all     (max_all),
        .nearest     (nearest),
        .free_idx    (free_idx),
        .best_idx    (best_idx),
        .best_track  (best_track)
    );

    // track fields are carried at TRACK_BITS internally
    assign req_trk_wide    = 32'(request.track);
    assign req_trk         = req_trk_wide[TRACK_BITS-1:0];
    assign start_head_wide = 32'(start_head_reg);
    assign start_head_tb   = start_head_wide[TRACK_BITS-1:0];
    assign served_wide     = 32'(best_track);
    assign out_of_range    = 32'(req_trk) >= 32'(track_count_reg);

    assign scan_last      = rd_valid_reg && (rd_idx_reg == LAST_ADDR);

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        trk_next        = trk_reg;
        op_next         = op_reg;
        target_next     = target_reg;
        match_next      = match_reg;
        head_next       = head_reg;
        sweep_left_next = sweep_left_reg;
        pending_next    = pending_reg;
        arrival_next    = arrival_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_addr_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        scan_ctl.init   = 1'b0;
        scan_ctl.take   = rd_valid_reg;
        scan_ctl.match  = match_reg;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en          = 1'b1;
                scan_addr_next = AW'(scan_addr_reg + 1'b1);
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                    if (state_reg == ST_CLEAR)
                    begin
                        done_next          = 1'b1;
                        result_next.status = STATUS_ACCEPTED;
                    end
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next                  = request.operation;
                    trk_next                 = req_trk;
                    scan_addr_next           = '0;
                    issue_done_next          = 1'b0;
                    result_next.served_track = '0;
                    unique case (request.operation)
                        OP_CLEAR:
                        begin
                            pending_next    = '0;
                            head_next       = start_head_tb;
                            sweep_left_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        OP_ADD:
                        begin
                            priority if (out_of_range)
                            begin
                                done_next          = 1'b1;
                                result_next.status = STATUS_OUT_RANGE;
                            end
                            else if (pending_reg == FULL_COUNT)
                            begin
                                done_next          = 1'b1;
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                scan_ctl.init = 1'b1;
                                state_next    = ST_SCAN_FREE;
                            end
                        end
                        OP_SERVE_FCFS, OP_SERVE_SSTF, OP_SERVE_LOOK, OP_SERVE_CLOOK:
                        begin
                            if (pending_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                scan_ctl.init = 1'b1;
                                match_next    = 1'b0;
                                state_next    = (request.operation == OP_SERVE_FCFS)
                                                ? ST_SCAN_AGE : ST_SCAN_TRACK;
                            end
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next.status = STATUS_ACCEPTED;
                        end
                    endcase
                end
            end
            ST_SCAN_FREE, ST_SCAN_TRACK, ST_SCAN_AGE:
            begin
                rd_en = !issue_done_reg;
                if (!issue_done_reg)
                begin
                    scan_addr_next = AW'(scan_addr_reg + 1'b1);
                    if (scan_addr_reg == LAST_ADDR)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (scan_last)
                begin
                    priority if (state_reg == ST_SCAN_FREE)
                    begin
                        state_next = ST_INSERT;
                    end
                    else if (state_reg == ST_SCAN_TRACK)
                    begin
                        state_next = ST_PICK;
                    end
                    else
                    begin
                        state_next = ST_REMOVE;
                    end
                end
            end
            ST_INSERT:
            begin
                wr_en              = 1'b1;
                wr_addr            = free_idx;
                wr_data            = {1'b1, trk_reg, arrival_reg};
                arrival_next       = arrival_reg + 1'b1;
                pending_next       = PCW'(pending_reg + 1'b1);
                done_next          = 1'b1;
                result_next.status = STATUS_ACCEPTED;
                state_next         = ST_IDLE;
            end
            ST_PICK:
            begin
                priority if (op_reg == OP_SERVE_SSTF)
                begin
                    target_next = nearest;
                end
                else if (op_reg == OP_SERVE_LOOK)
                begin
                    // reverse when nothing lies in the sweep direction
                    if (sweep_left_reg)
                    begin
                        if (scan_flags.below_found)
                        begin
                            target_next = max_below;
                        end
                        else
                        begin
                            sweep_left_next = 1'b0;
                            target_next     = min_above;
                        end
                    end
                    else
                    begin
                        if (scan_flags.above_found)
                        begin
                            target_next = min_above;
                        end
                        else
                        begin
                            sweep_left_next = 1'b1;
                            target_next     = max_below;
                        end
                    end
                end
                else
                begin
                    target_next = scan_flags.below_found ? max_below : max_all;
                end
                scan_ctl.init   = 1'b1;
                match_next      = 1'b1;
                scan_addr_next  = '0;
                issue_done_next = 1'b0;
                state_next      = ST_SCAN_AGE;
            end
            ST_REMOVE:
            begin
                wr_en                    = 1'b1;
                wr_addr                  = best_idx;
                wr_data                  = '0;
                pending_next             = PCW'(pending_reg - 1'b1);
                head_next                = best_track;
                done_next                = 1'b1;
                result_next.served_track = served_wide[TRACK_FIELD_BITS-1:0];
                result_next.status       = STATUS_SERVED;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            op_reg         <= OP_CLEAR;
            match_reg      <= 1'b0;
            head_reg       <= '0;
            sweep_left_reg <= 1'b1;
            pending_reg    <= '0;
            arrival_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_en;
            op_reg         <= op_next;
            match_reg      <= match_next;
            head_reg       <= head_next;
            sweep_left_reg <= sweep_left_next;
            pending_reg    <= pending_next;
            arrival_reg    <= arrival_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_addr_reg;
        trk_reg    <= trk_next;
        target_reg <= target_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg <= TRACK_COUNT_RESET;
            start_head_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TRACK_COUNT: track_count_reg <= cfg_data;
                CFG_START_HEAD:  start_head_reg  <= cfg_data[TRACK_FIELD_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= FULL_COUNT)
        else $error("pending count above depth");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("request accepted but neither answered nor in progress");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !wr_en)
        else $error("memory written while idle");

    a_serve_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == STATUS_SERVED
            |-> $past(pending_reg) - pending_reg == PCW'(1))
        else $error("serve did not remove exactly one entry");

endmodule
